// ===== sv/cba_pkg.sv =====
package cba_pkg;

  localparam int unsigned MAX_CHUNKS_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF  = 32;

  // wide enough for any size width plus an alignment carry
  localparam int unsigned AW             = 50;
  localparam int unsigned ALIGN_LOG2_MAX = 16;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned REQ_W      = 32;

  localparam logic [4:0]  ALIGN_LOG2_RST  = 5'd8;
  localparam logic [31:0] FIRST_SIZE_RST  = 32'd65536;
  localparam logic [15:0] GROW_SCALE_RST  = 16'd256;
  localparam logic [31:0] GROW_BIAS_RST   = 32'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALIGN_LOG2  = 2'd0,
    CFG_FIRST_SIZE  = 2'd1,
    CFG_GROW_SCALE  = 2'd2,
    CFG_GROW_BIAS   = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_SLOT  = 2'd2
  } status_e;

  localparam int unsigned OP_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_RESET = 2'd1,
    OP_BAD   = 2'd2
  } op_e;

  // round up to 2^lg, clamp lg at 16, saturate at smax
  function automatic logic [AW-1:0] align_up(input logic [AW-1:0] x,
                                             input logic [4:0] lg,
                                             input logic [AW-1:0] smax);
    logic [4:0]    lgc;
    logic [AW-1:0] mask;
    logic [AW-1:0] r;
    lgc  = (lg > 5'(ALIGN_LOG2_MAX)) ? 5'(ALIGN_LOG2_MAX) : lg;
    mask = (AW'(1) << lgc) - AW'(1);
    r    = (x + mask) & ~mask;
    return (r > smax) ? smax : r;
  endfunction

endpackage

// ===== sv/chunked_bump_allocator.sv =====
// channel   direction  handshake               payload
// in        request    in_valid_i/in_stall_o    in_mode_i, in_request_size_i
// out       result     out_valid_o/out_stall_i  out_chunk_index_o .. out_status_o
// cfg       write      cfg_we_i                 cfg_index_i, cfg_data_i
//
// a request sits in a two-entry queue; the back end answers a reset or bad size
// straight from idle, walks the chunks in the check state for an allocate, and
// goes through the grow and append states when a chunk is appended (straight to
// append when no chunk exists yet); the chunk memory read port sets the walk pace
// reset clears counts and the current position; the chunk memory is not cleared
// in_stall_o rises only when the queue is full; a held result blocks the back end
module chunked_bump_allocator #(
  parameter int unsigned MAX_CHUNKS = cba_pkg::MAX_CHUNKS_DEF,
  parameter int unsigned SIZE_BITS  = cba_pkg::SIZE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cba_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cba_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            in_mode_i,
  input  logic [cba_pkg::REQ_W-1:0]       in_request_size_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [3:0]                      out_chunk_index_o,
  output logic [31:0]                     out_block_offset_o,
  output logic                            out_chunk_created_o,
  output logic [31:0]                     out_new_chunk_size_o,
  output logic [1:0]                      out_status_o
);

  localparam int unsigned QW = cba_pkg::OP_W + SIZE_BITS;

  logic [4:0]  align_q;
  logic [31:0] first_q;
  logic [15:0] scale_q;
  logic [31:0] bias_q;

  cba_pkg::op_e          f_op;
  logic [SIZE_BITS-1:0]  f_size;
  logic [QW-1:0]         q_dout;
  logic                  q_valid;
  logic                  q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      align_q <= cba_pkg::ALIGN_LOG2_RST;
      first_q <= cba_pkg::FIRST_SIZE_RST;
      scale_q <= cba_pkg::GROW_SCALE_RST;
      bias_q  <= cba_pkg::GROW_BIAS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cba_pkg::CFG_ALIGN_LOG2: align_q <= cfg_data_i[4:0];
        cba_pkg::CFG_FIRST_SIZE: first_q <= cfg_data_i[31:0];
        cba_pkg::CFG_GROW_SCALE: scale_q <= cfg_data_i[15:0];
        cba_pkg::CFG_GROW_BIAS:  bias_q  <= cfg_data_i[31:0];
        default: begin
        end
      endcase
    end
  end

  cba_front #(
    .SIZE_BITS (SIZE_BITS)
  ) u_front (
    .mode_i             (in_mode_i),
    .request_size_i     (in_request_size_i),
    .align_log2_i       (align_q),
    .first_chunk_size_i (first_q),
    .op_o               (f_op),
    .size_o             (f_size)
  );

  cba_queue #(
    .DW (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_stall_o (in_stall_o),
    .push_data_i  ({f_op, f_size}),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_data_o   (q_dout)
  );

  cba_back #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .q_valid_i            (q_valid),
    .q_op_i               (cba_pkg::op_e'(q_dout[QW-1:SIZE_BITS])),
    .q_size_i             (q_dout[SIZE_BITS-1:0]),
    .q_pop_o              (q_pop),
    .align_log2_i         (align_q),
    .first_chunk_size_i   (first_q),
    .growth_scale_q8_i    (scale_q),
    .growth_bias_i        (bias_q),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_chunk_index_o    (out_chunk_index_o),
    .out_block_offset_o   (out_block_offset_o),
    .out_chunk_created_o  (out_chunk_created_o),
    .out_new_chunk_size_o (out_new_chunk_size_o),
    .out_status_o         (out_status_o)
  );

endmodule

// ===== sv/cba_front.sv =====
module cba_front #(
  parameter int unsigned SIZE_BITS = cba_pkg::SIZE_BITS_DEF
) (
  input  logic                       mode_i,
  input  logic [cba_pkg::REQ_W-1:0]  request_size_i,
  input  logic [4:0]                 align_log2_i,
  input  logic [31:0]                first_chunk_size_i,
  output cba_pkg::op_e               op_o,
  output logic [SIZE_BITS-1:0]       size_o
);

  localparam logic [cba_pkg::AW-1:0] SMAX_W =
    (cba_pkg::AW'(1) << SIZE_BITS) - cba_pkg::AW'(1);

  logic [cba_pkg::AW-1:0] first_w;
  logic [cba_pkg::AW-1:0] first_sat;
  logic [cba_pkg::AW-1:0] size_w;

  always_comb begin
    first_w   = cba_pkg::AW'(first_chunk_size_i);
    first_sat = (first_w > SMAX_W) ? SMAX_W : first_w;
    size_w    = cba_pkg::align_up(cba_pkg::AW'(request_size_i), align_log2_i, SMAX_W);
    size_o    = size_w[SIZE_BITS-1:0];
    if (mode_i) begin
      op_o = cba_pkg::OP_RESET;
    end else if (size_w == '0 || size_w > first_sat) begin
      op_o = cba_pkg::OP_BAD;
    end else begin
      op_o = cba_pkg::OP_ALLOC;
    end
  end

endmodule

// ===== sv/cba_queue.sv =====
module cba_queue #(
  parameter int unsigned DW = 34
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_stall_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output logic [DW-1:0] pop_data_o
);

  logic [DW-1:0] entry_q [2];
  logic          wr_q, wr_d;
  logic          rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push;
  logic          pop;

  assign push_stall_o = (cnt_q == 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = entry_q[rd_q];
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/cba_back.sv =====
module cba_back #(
  parameter int unsigned MAX_CHUNKS = cba_pkg::MAX_CHUNKS_DEF,
  parameter int unsigned SIZE_BITS  = cba_pkg::SIZE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  cba_pkg::op_e         q_op_i,
  input  logic [SIZE_BITS-1:0] q_size_i,
  output logic                 q_pop_o,
  input  logic [4:0]           align_log2_i,
  input  logic [31:0]          first_chunk_size_i,
  input  logic [15:0]          growth_scale_q8_i,
  input  logic [31:0]          growth_bias_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [3:0]           out_chunk_index_o,
  output logic [31:0]          out_block_offset_o,
  output logic                 out_chunk_created_o,
  output logic [31:0]          out_new_chunk_size_o,
  output logic [1:0]           out_status_o
);

  localparam int unsigned SW = SIZE_BITS;
  localparam int unsigned IW = $clog2(MAX_CHUNKS);
  localparam int unsigned CW = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned BW = ((SW > 32) ? SW : 32) + 1;
  localparam int unsigned PW = SW + 16;
  localparam logic [cba_pkg::AW-1:0] SMAX_W =
    (cba_pkg::AW'(1) << SW) - cba_pkg::AW'(1);
  localparam logic [SW-1:0] SMAX_S = {SW{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_GROW   = 4'b0100,
    S_APPEND = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] cur_q, cur_d;
  logic [SW-1:0] off_q, off_d;
  logic          have_q, have_d;
  logic [IW-1:0] scur_q, scur_d;
  logic [SW-1:0] soff_q, soff_d;
  logic [SW-1:0] size_q, size_d;
  logic [PW-1:0] prod_q, prod_d;
  logic [SW-1:0] grow_q, grow_d;

  logic          out_valid_q, out_valid_d;
  logic [3:0]    out_idx_q, out_idx_d;
  logic [31:0]   out_off_q, out_off_d;
  logic          out_new_q, out_new_d;
  logic [31:0]   out_nsz_q, out_nsz_d;
  logic [1:0]    out_st_q, out_st_d;
  logic          out_free;
  logic          load;

  logic [SW-1:0] size_mem [MAX_CHUNKS];
  logic [SW-1:0] rdata_q;
  logic [IW-1:0] rd_addr;
  logic          wr_en;

  logic [SW:0]              fit_sum;
  logic                     fits;
  logic [SW-1:0]            sat1;
  logic [BW-1:0]            bsum;
  logic [cba_pkg::AW-1:0]   first_w;
  logic [cba_pkg::AW-1:0]   first_sat;
  logic [cba_pkg::AW-1:0]   base_w;
  logic [cba_pkg::AW-1:0]   gal_w;
  logic [SW-1:0]            new_sz;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    fit_sum   = {1'b0, soff_q} + {1'b0, size_q};
    fits      = fit_sum <= {1'b0, rdata_q};
    sat1      = (|prod_q[PW-1:SW+8]) ? SMAX_S : prod_q[SW+7:8];
    bsum      = BW'(sat1) + BW'(growth_bias_i);
    first_w   = cba_pkg::AW'(first_chunk_size_i);
    first_sat = (first_w > SMAX_W) ? SMAX_W : first_w;
    base_w    = cba_pkg::align_up(first_sat, align_log2_i, SMAX_W);
    gal_w     = cba_pkg::align_up(cba_pkg::AW'(grow_q), align_log2_i, SMAX_W);
    new_sz    = (gal_w < base_w) ? base_w[SW-1:0] : gal_w[SW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    off_d       = off_q;
    have_d      = have_q;
    scur_d      = scur_q;
    soff_d      = soff_q;
    size_d      = size_q;
    prod_d      = prod_q;
    grow_d      = grow_q;
    rd_addr     = scur_q;
    wr_en       = 1'b0;
    q_pop_o     = 1'b0;
    load        = 1'b0;
    out_idx_d   = out_idx_q;
    out_off_d   = out_off_q;
    out_new_d   = out_new_q;
    out_nsz_d   = out_nsz_q;
    out_st_d    = out_st_q;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o   = 1'b1;
          size_d    = q_size_i;
          out_idx_d = 4'd0;
          out_off_d = 32'd0;
          out_new_d = 1'b0;
          out_nsz_d = 32'd0;
          out_st_d  = cba_pkg::ST_OK;
          case (q_op_i)
            cba_pkg::OP_RESET: begin
              cur_d  = '0;
              off_d  = '0;
              have_d = (cnt_q != '0);
              load   = 1'b1;
            end
            cba_pkg::OP_ALLOC: begin
              if (have_q) begin
                scur_d  = cur_q;
                soff_d  = off_q;
                rd_addr = cur_q;
                state_d = S_CHECK;
              end else begin
                grow_d  = '0;
                state_d = S_APPEND;
              end
            end
            default: begin
              out_st_d = cba_pkg::ST_BAD_SIZE;
              load     = 1'b1;
            end
          endcase
        end
      end
      S_CHECK: begin
        prod_d = rdata_q * growth_scale_q8_i;
        if (fits) begin
          cur_d     = scur_q;
          off_d     = fit_sum[SW-1:0];
          have_d    = 1'b1;
          out_idx_d = 4'(scur_q);
          out_off_d = 32'(soff_q);
          load      = 1'b1;
          state_d   = S_IDLE;
        end else if ((CW+1)'(scur_q) + (CW+1)'(1) < (CW+1)'(cnt_q)) begin
          scur_d  = scur_q + IW'(1);
          soff_d  = '0;
          rd_addr = scur_q + IW'(1);
        end else if (cnt_q < CW'(MAX_CHUNKS)) begin
          state_d = S_GROW;
        end else begin
          out_st_d = cba_pkg::ST_NO_SLOT;
          load     = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_GROW: begin
        grow_d  = (bsum > BW'(SMAX_S)) ? SMAX_S : bsum[SW-1:0];
        state_d = S_APPEND;
      end
      S_APPEND: begin
        wr_en     = 1'b1;
        cur_d     = cnt_q[IW-1:0];
        off_d     = size_q;
        have_d    = 1'b1;
        cnt_d     = cnt_q + CW'(1);
        out_idx_d = 4'(cnt_q[IW-1:0]);
        out_off_d = 32'd0;
        out_new_d = 1'b1;
        out_nsz_d = 32'(new_sz);
        out_st_d  = cba_pkg::ST_OK;
        load      = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      cur_q       <= '0;
      off_q       <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      off_q       <= off_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scur_q    <= scur_d;
    soff_q    <= soff_d;
    size_q    <= size_d;
    prod_q    <= prod_d;
    grow_q    <= grow_d;
    out_idx_q <= out_idx_d;
    out_off_q <= out_off_d;
    out_new_q <= out_new_d;
    out_nsz_q <= out_nsz_d;
    out_st_q  <= out_st_d;
  end

  // chunk size memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      size_mem[cnt_q[IW-1:0]] <= new_sz;
    end
    rdata_q <= size_mem[rd_addr];
  end

  assign out_valid_o          = out_valid_q;
  assign out_chunk_index_o    = out_idx_q;
  assign out_block_offset_o   = out_off_q;
  assign out_chunk_created_o  = out_new_q;
  assign out_new_chunk_size_o = out_nsz_q;
  assign out_status_o         = out_st_q;

endmodule

// ===== bench/cba_grant_check.sv =====
module cba_grant_check
  import cba_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  in_mode_i,
  input  logic [REQ_W-1:0]      in_request_size_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [3:0]            out_chunk_index_i,
  input  logic [31:0]           out_block_offset_i,
  input  logic                  out_chunk_created_i,
  input  logic [31:0]           out_new_chunk_size_i,
  input  logic [1:0]            out_status_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o,
  output int unsigned           appended_o,
  output int unsigned           no_slot_o
);

  localparam logic [63:0] SIZE_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [3:0]  chunk;
    logic [31:0] offset;
    logic        created;
    logic [31:0] new_size;
    status_e     status;
  } grant_t;

  logic [4:0]  align_lg;
  logic [31:0] first_size;
  logic [15:0] scale_q8;
  logic [31:0] bias;

  logic [63:0] chunk_sizes [MAX_CHUNKS];
  int unsigned n_chunks;
  int unsigned cur_chunk;
  logic        have_cur;
  logic [63:0] cur_off;

  grant_t grants_due [$];

  function automatic logic [63:0] round_up(input logic [63:0] x);
    int unsigned sh;
    logic [63:0] r;
    sh = (align_lg > 5'd16) ? 16 : int'(align_lg);
    r  = ((x + (64'd1 << sh) - 64'd1) >> sh) << sh;
    return (r > SIZE_MAX) ? SIZE_MAX : r;
  endfunction

  function automatic grant_t grant_for(input logic mode, input logic [31:0] req);
    grant_t      g;
    logic [63:0] need;
    logic [63:0] off;
    logic [63:0] grown;
    logic [63:0] base;
    logic [63:0] nsz;
    int unsigned c;
    logic        h;
    logic        done;
    g = '0;
    g.status = ST_OK;
    if (mode == 1'(OP_RESET)) begin
      cur_chunk = 0;
      cur_off   = 64'd0;
      have_cur  = (n_chunks != 0);
      return g;
    end
    need = round_up(64'(req));
    if (need == 64'd0 || need > 64'(first_size)) begin
      g.status = ST_BAD_SIZE;
      return g;
    end
    c = cur_chunk;
    off = cur_off;
    h = have_cur;
    g.status = ST_NO_SLOT;
    done = 1'b0;
    while (!done) begin
      if (h && off + need <= chunk_sizes[c]) begin
        cur_chunk = c;
        cur_off   = off + need;
        have_cur  = 1'b1;
        g.chunk   = 4'(c);
        g.offset  = off[31:0];
        g.status  = ST_OK;
        done      = 1'b1;
      end else if (h && c + 1 < n_chunks) begin
        c   = c + 1;
        off = 64'd0;
      end else begin
        if (n_chunks < MAX_CHUNKS) begin
          base = round_up(64'(first_size));
          nsz  = base;
          if (h) begin
            // grow from the chunk the walk stopped on
            grown = (chunk_sizes[c] * 64'(scale_q8)) >> 8;
            if (grown > SIZE_MAX) grown = SIZE_MAX;
            grown = grown + 64'(bias);
            if (grown > SIZE_MAX) grown = SIZE_MAX;
            grown = round_up(grown);
            if (grown > base) nsz = grown;
          end
          if (need <= nsz) begin
            chunk_sizes[n_chunks] = nsz;
            cur_chunk  = n_chunks;
            cur_off    = need;
            have_cur   = 1'b1;
            g.chunk    = 4'(n_chunks);
            g.created  = 1'b1;
            g.new_size = nsz[31:0];
            g.status   = ST_OK;
            n_chunks   = n_chunks + 1;
          end
        end
        done = 1'b1;
      end
    end
    return g;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o = fail_count_o + 1;
    end
  endfunction

  always @(posedge clk_i) begin
    grant_t want;
    grant_t g;
    if (!rst_ni) begin
      align_lg   = ALIGN_LOG2_RST;
      first_size = FIRST_SIZE_RST;
      scale_q8   = GROW_SCALE_RST;
      bias       = GROW_BIAS_RST;
      n_chunks   = 0;
      cur_chunk  = 0;
      have_cur   = 1'b0;
      cur_off    = 64'd0;
      grants_due.delete();
      fail_count_o = 0;
      appended_o   = 0;
      no_slot_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (grants_due.size() == 0) begin
          $error("result with no request outstanding");
          fail_count_o = fail_count_o + 1;
        end else begin
          want = grants_due.pop_front();
          check_field("chunk_index", 32'(want.chunk), 32'(out_chunk_index_i));
          check_field("block_offset", want.offset, out_block_offset_i);
          check_field("chunk_created", 32'(want.created), 32'(out_chunk_created_i));
          check_field("new_chunk_size", want.new_size, out_new_chunk_size_i);
          check_field("status", 32'(want.status), 32'(out_status_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        g = grant_for(in_mode_i, in_request_size_i);
        if (g.created) appended_o = appended_o + 1;
        if (g.status == ST_NO_SLOT) no_slot_o = no_slot_o + 1;
        grants_due.push_back(g);
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_ALIGN_LOG2: align_lg   = cfg_data_i[4:0];
          CFG_FIRST_SIZE: first_size = cfg_data_i[31:0];
          CFG_GROW_SCALE: scale_q8   = cfg_data_i[15:0];
          CFG_GROW_BIAS:  bias       = cfg_data_i[31:0];
          default: ;
        endcase
      end
    end
    pending_o = grants_due.size();
  end

endmodule

// ===== bench/tb_chunked_bump_allocator.sv =====
module tb_chunked_bump_allocator;
  import cba_pkg::*;

  localparam int unsigned MAX_CHUNKS = 16;
  localparam logic ALLOC       = 1'(OP_ALLOC);
  localparam logic RESET_STACK = 1'(OP_RESET);

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_mode  = 1'b0;
  logic [REQ_W-1:0] in_size  = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_chunk;
  logic [31:0] out_offset;
  logic        out_created;
  logic [31:0] out_new_size;
  logic [1:0]  out_status;

  int unsigned fails;
  int unsigned pending;
  int unsigned appended;
  int unsigned no_slot;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned sent      = 0;
  int unsigned settings  = 0;
  logic [4:0]  cur_align = ALIGN_LOG2_RST;
  logic [31:0] cur_first = FIRST_SIZE_RST;

  chunked_bump_allocator #(
    .MAX_CHUNKS(MAX_CHUNKS),
    .SIZE_BITS (32)
  ) dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .in_mode_i           (in_mode),
    .in_request_size_i   (in_size),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .out_chunk_index_o   (out_chunk),
    .out_block_offset_o  (out_offset),
    .out_chunk_created_o (out_created),
    .out_new_chunk_size_o(out_new_size),
    .out_status_o        (out_status)
  );

  cba_grant_check #(
    .MAX_CHUNKS(MAX_CHUNKS)
  ) grant_check (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .in_mode_i           (in_mode),
    .in_request_size_i   (in_size),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .out_chunk_index_i   (out_chunk),
    .out_block_offset_i  (out_offset),
    .out_chunk_created_i (out_created),
    .out_new_chunk_size_i(out_new_size),
    .out_status_i        (out_status),
    .fail_count_o        (fails),
    .pending_o           (pending),
    .appended_o          (appended),
    .no_slot_o           (no_slot)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send(input logic mode, input logic [31:0] size);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_size  <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent = sent + 1;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_regs(input logic [4:0] lg, input logic [31:0] first,
                            input logic [15:0] scale, input logic [31:0] bias);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ALIGN_LOG2;
    cfg_data  <= 32'(lg);
    @(posedge clk);
    cfg_index <= CFG_FIRST_SIZE;
    cfg_data  <= first;
    @(posedge clk);
    cfg_index <= CFG_GROW_SCALE;
    cfg_data  <= 32'(scale);
    @(posedge clk);
    cfg_index <= CFG_GROW_BIAS;
    cfg_data  <= bias;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_align = lg;
    cur_first = first;
    settings  = settings + 1;
  endtask

  // largest aligned request that still passes the size check, or cur_first when none does
  function automatic logic [31:0] full_size();
    logic [31:0] mask;
    mask = (32'd1 << ((cur_align > 5'd16) ? 16 : int'(cur_align))) - 32'd1;
    return ((cur_first & ~mask) != 0) ? (cur_first & ~mask) : cur_first;
  endfunction

  function automatic logic [31:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return (cur_first != 0) ? $urandom_range(cur_first, 1) : $urandom;
    if (r < 55) return $urandom_range(300, 1);
    if (r < 63) return cur_first;
    if (r < 68) return cur_first + 32'd1;
    if (r < 74) return cur_first - $urandom_range(3);
    if (r < 80) return 32'd0;
    if (r < 90) return $urandom;
    return cur_first >> $urandom_range(4, 1);
  endfunction

  task automatic run_phase(input logic [4:0] lg, input logic [31:0] first,
                           input logic [15:0] scale, input logic [31:0] bias,
                           input int unsigned count);
    drain;
    write_regs(lg, first, scale, bias);
    // walk forward so the new growth setting gets to append chunks
    repeat (4) send(ALLOC, full_size());
    repeat (count) begin
      if ($urandom_range(99) < 6) send(RESET_STACK, $urandom);
      else send(ALLOC, pick_size());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_pct  = 22;
    stall_pct = 22;

    // bad sizes and a stack reset before any chunk exists
    send(ALLOC, 32'd0);
    send(ALLOC, 32'hFFFF_FFFF);
    send(ALLOC, 32'd65537);
    send(RESET_STACK, 32'hFFFF_FFFF);
    // first chunk, alignment, appends
    send(ALLOC, 32'd1);
    send(ALLOC, 32'd255);
    send(ALLOC, 32'd65536);
    send(ALLOC, 32'd65536);
    // rewind and reuse known chunks, with a walk past a full one
    send(RESET_STACK, 32'd0);
    send(ALLOC, 32'd65000);
    send(ALLOC, 32'd1024);
    send(ALLOC, 32'd65536);
    send(RESET_STACK, 32'h5A5A_5A5A);
    repeat (4) send(ALLOC, 32'd65536);
    send(ALLOC, 32'd256);

    run_phase(5'd0, 32'd1, 16'hFFFF, 32'hFFFF_FFFF, 70);
    run_phase(5'd4, 32'd4096, 16'd384, 32'd100, 70);
    run_phase(5'd16, 32'hFFFF_FFFF, 16'd256, 32'd0, 70);
    run_phase(5'd31, 32'd200000, 16'd128, 32'd0, 70);
    run_phase(5'd2, 32'd1000, 16'd0, 32'd7, 60);
    run_phase(5'd3, 32'd0, 16'd512, 32'd1, 20);
    run_phase(5'($urandom_range(31)), $urandom_range(32'h0010_0000, 1),
              16'($urandom_range(65535)), $urandom_range(5000), 70);
    run_phase(5'($urandom_range(31)), $urandom, 16'($urandom_range(65535)), $urandom, 70);
    run_phase(5'($urandom_range(12)), $urandom_range(32'h0004_0000, 64),
              16'($urandom_range(1024, 256)), $urandom_range(300), 70);
    idle_pct  = 0;
    stall_pct = 0;
    run_phase(ALIGN_LOG2_RST, FIRST_SIZE_RST, GROW_SCALE_RST, GROW_BIAS_RST, 70);
    idle_pct  = 22;
    stall_pct = 22;

    // whole-range requests until the chunk slots run out
    drain;
    write_regs(5'd0, 32'hFFFF_FFFF, 16'd256, 32'd0);
    send(RESET_STACK, 32'd0);
    repeat (3) send(ALLOC, 32'hFFFF_FFFF);
    send(RESET_STACK, 32'd1);

    drain;
    repeat (40) @(negedge clk);
    $display("%0d requests over %0d register settings plus reset values", sent, settings);
    $display("%0d chunk appends, %0d requests refused for lack of a chunk slot",
             appended, no_slot);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(64'd12 * 64'd400_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== chunked_bump_allocator.f =====
sv/cba_pkg.sv
sv/cba_front.sv
sv/cba_queue.sv
sv/cba_back.sv
sv/chunked_bump_allocator.sv
bench/cba_grant_check.sv
bench/tb_chunked_bump_allocator.sv
